FILE: hw/rtl/lfu_pkg.sv
package lfu_pkg;

	localparam int KEY_W         = 32;
	localparam int VAL_W         = 32;
	localparam int CNT_W         = 16;
	localparam int STAMP_W       = 32;
	localparam int CAP_W         = 5;
	localparam int MAX_ENTRIES_DEF = 16;

	localparam logic [CAP_W-1:0] CAPACITY_RST = CAP_W'(16);
	localparam logic [CNT_W-1:0] COUNT_MAX    = '1;
	localparam logic [CNT_W-1:0] COUNT_ONE    = CNT_W'(1);

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   val;
		logic [CNT_W-1:0]   use_count;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DRAIN  = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

endpackage

FILE: hw/rtl/lfu_ram.sv
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/lfu_cache_lru_tiebreak.sv
// Key/value store, LFU replacement with oldest-stamp tie-break.
// Input channel (in_valid/in_ready) carries one word: op (0 get, 1 put),
// key and value. Output channel (out_valid/out_ready) returns one word per
// input: hit, read_value (get hit only) and evicted (put that displaced an
// entry). cfg_we/cfg_wdata write capacity; the user writes it only while
// the block is idle; the block itself does not enforce this. Each input
// scans every slot through the entry RAM, one slot per cycle, with a
// single count/stamp comparator; a drain state and an update state that
// writes the entry back follow. A new word is taken only in idle, the
// cycle after the result is registered, never while one is in flight.
// The result sits in an output register: a stalled receiver holds the
// result there while the next word is accepted, scanned and written back;
// the block then holds its new result until the register frees.
// Reset clears all valid bits, the stamp counter and the occupancy, and
// sets capacity to 16; the block is ready as soon as reset releases.
module lfu_cache_lru_tiebreak #(
	parameter int MAX_ENTRIES = lfu_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        op,
	input  logic [lfu_pkg::KEY_W-1:0]   key,
	input  logic [lfu_pkg::VAL_W-1:0]   value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output logic [lfu_pkg::VAL_W-1:0]   read_value,
	output logic                        evicted
);

	import lfu_pkg::*;

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

	state_t state_q;

	logic [CAP_W-1:0]    capacity_q;
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [STAMP_W-1:0]  stamp_q;
	logic [CAP_W-1:0]    occ_q;

	logic                op_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    value_q;

	logic [IW-1:0]       idx_q;
	logic                scan_s1;
	logic [IW-1:0]       idx_s1;

	logic                found_q;
	logic [IW-1:0]       found_idx_q;
	logic [VAL_W-1:0]    found_val_q;
	logic [CNT_W-1:0]    found_cnt_q;
	logic                free_found_q;
	logic [IW-1:0]       free_idx_q;
	logic                victim_found_q;
	logic [IW-1:0]       victim_idx_q;
	logic [CNT_W-1:0]    best_cnt_q;
	logic [STAMP_W-1:0]  best_stamp_q;

	logic                res_hit_q;
	logic [VAL_W-1:0]    res_rd_q;
	logic                res_ev_q;

	logic [ENTRY_W-1:0]  rdata;
	entry_t              rd_e;
	logic                slot_vld;
	logic                match;
	logic                better;

	logic                do_write;
	logic                set_valid;
	logic                occ_inc;
	logic                ev;
	logic [VAL_W-1:0]    rd_val;
	logic [IW-1:0]       wr_idx;
	entry_t              wr_e;
	logic [CNT_W-1:0]    bumped;
	logic                has_room;

	assign in_ready = (state_q == ST_IDLE);

	lfu_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (do_write && (state_q == ST_UPDATE)),
		.waddr(wr_idx),
		.wdata(wr_e),
		.raddr(idx_q),
		.rdata(rdata)
	);

	assign rd_e     = entry_t'(rdata);
	assign slot_vld = valid_q[idx_s1];
	assign match    = scan_s1 && slot_vld && !found_q && (rd_e.key == key_q);
	assign better   = scan_s1 && slot_vld &&
		(!victim_found_q || (rd_e.use_count < best_cnt_q) ||
		 ((rd_e.use_count == best_cnt_q) && (rd_e.stamp < best_stamp_q)));

	assign bumped   = (found_cnt_q == COUNT_MAX) ? COUNT_MAX : found_cnt_q + COUNT_ONE;
	assign has_room = (occ_q < capacity_q) && (int'(occ_q) < MAX_ENTRIES);

	always_comb begin
		do_write  = 1'b0;
		set_valid = 1'b0;
		occ_inc   = 1'b0;
		ev        = 1'b0;
		rd_val    = '0;
		wr_idx    = found_idx_q;
		wr_e      = '{key: key_q, val: value_q, use_count: bumped, stamp: stamp_q};
		if (op_q == OP_GET) begin
			if (found_q) begin
				do_write  = 1'b1;
				rd_val    = found_val_q;
				wr_e.val  = found_val_q;
			end
		end else if (capacity_q != '0) begin
			if (found_q) begin
				do_write = 1'b1;
			end else begin
				wr_e.use_count = COUNT_ONE;
				if (has_room && free_found_q) begin
					do_write  = 1'b1;
					set_valid = 1'b1;
					occ_inc   = 1'b1;
					wr_idx    = free_idx_q;
				end else if (victim_found_q) begin
					do_write  = 1'b1;
					set_valid = 1'b1;
					ev        = 1'b1;
					wr_idx    = victim_idx_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			capacity_q     <= CAPACITY_RST;
			valid_q        <= '0;
			stamp_q        <= '0;
			occ_q          <= '0;
			idx_q          <= '0;
			scan_s1        <= 1'b0;
			found_q        <= 1'b0;
			free_found_q   <= 1'b0;
			victim_found_q <= 1'b0;
			out_valid      <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			scan_s1 <= (state_q == ST_SCAN);
			if (match) begin
				found_q <= 1'b1;
			end
			if (better) begin
				victim_found_q <= 1'b1;
			end
			if (scan_s1 && !slot_vld && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						found_q        <= 1'b0;
						free_found_q   <= 1'b0;
						victim_found_q <= 1'b0;
						idx_q          <= '0;
						state_q        <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (do_write) begin
						stamp_q <= stamp_q + STAMP_W'(1);
					end
					if (set_valid) begin
						valid_q[wr_idx] <= 1'b1;
					end
					if (occ_inc) begin
						occ_q <= occ_q + CAP_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (in_valid && in_ready) begin
			op_q    <= op;
			key_q   <= key;
			value_q <= value;
		end
		if (match) begin
			found_idx_q <= idx_s1;
			found_val_q <= rd_e.val;
			found_cnt_q <= rd_e.use_count;
		end
		if (better) begin
			victim_idx_q <= idx_s1;
			best_cnt_q   <= rd_e.use_count;
			best_stamp_q <= rd_e.stamp;
		end
		if (scan_s1 && !slot_vld && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		if (state_q == ST_UPDATE) begin
			res_hit_q <= found_q;
			res_rd_q  <= rd_val;
			res_ev_q  <= ev;
		end
		if ((state_q == ST_DONE) && (!out_valid || out_ready)) begin
			hit        <= res_hit_q;
			read_value <= res_rd_q;
			evicted    <= res_ev_q;
		end
	end

endmodule

FILE: tb/lfu_cache_lru_tiebreak_tb.sv
`timescale 1ns / 1ps

module lfu_cache_lru_tiebreak_tb;
	import lfu_pkg::*;

	localparam int NSLOT        = MAX_ENTRIES_DEF;
	localparam int DRAIN_CYCLES = 2 * (NSLOT + 4);
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SEG_WORDS    = 130;
	localparam int NSEG         = 15;
	localparam int NROW         = 25;
	localparam int POOL_N       = 24;
	localparam int MAX_PRINTS   = 30;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] rd;
		logic             ev;
	} lookup_res_t;

	typedef enum logic {ROW_WORD, ROW_CAP} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic             op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
		logic [CAP_W-1:0] cap;
		logic             has_exp;
		lookup_res_t      exp;
	} dir_row_t;

	// typed results only where they follow by inspection; the rest use the predictor
	localparam dir_row_t DIRECTED_ROWS [NROW] = '{
		'{ROW_WORD, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, '{1'b0, 32'h0, 1'b0}},
		'{ROW_WORD, OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0, 1'b1, '{1'b0, 32'h0, 1'b0}},
		'{ROW_WORD, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1,
			'{1'b1, 32'hFFFF_FFFF, 1'b0}},
		'{ROW_WORD, OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, '{1'b0, 32'h0, 1'b0}},
		'{ROW_WORD, OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1, '{1'b1, 32'h0, 1'b0}},
		'{ROW_WORD, OP_PUT, 32'h0000_0000, 32'h1234_5678, 5'd0, 1'b1, '{1'b1, 32'h0, 1'b0}},
		'{ROW_WORD, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1,
			'{1'b1, 32'h1234_5678, 1'b0}},
		// shrink below occupancy
		'{ROW_CAP,  OP_GET, 32'h0, 32'h0, 5'd1, 1'b0, '0},
		'{ROW_WORD, OP_PUT, 32'h0000_0005, 32'hA5A5_A5A5, 5'd0, 1'b1, '{1'b0, 32'h0, 1'b1}},
		'{ROW_WORD, OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, '{1'b0, 32'h0, 1'b0}},
		'{ROW_WORD, OP_PUT, 32'h0000_0006, 32'h5A5A_5A5A, 5'd0, 1'b1, '{1'b0, 32'h0, 1'b1}},
		'{ROW_WORD, OP_GET, 32'h0000_0006, 32'h0000_0000, 5'd0, 1'b0, '0},
		// storing disabled
		'{ROW_CAP,  OP_GET, 32'h0, 32'h0, 5'd0, 1'b0, '0},
		'{ROW_WORD, OP_PUT, 32'h0000_0000, 32'h0000_0001, 5'd0, 1'b1, '{1'b1, 32'h0, 1'b0}},
		'{ROW_WORD, OP_PUT, 32'h0000_0007, 32'h0000_0002, 5'd0, 1'b1, '{1'b0, 32'h0, 1'b0}},
		'{ROW_WORD, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1,
			'{1'b1, 32'h1234_5678, 1'b0}},
		'{ROW_WORD, OP_GET, 32'h0000_0007, 32'h0000_0000, 5'd0, 1'b1, '{1'b0, 32'h0, 1'b0}},
		// above slot count, clamps
		'{ROW_CAP,  OP_GET, 32'h0, 32'h0, 5'd31, 1'b0, '0},
		'{ROW_WORD, OP_PUT, 32'h0000_0008, 32'hDEAD_BEEF, 5'd0, 1'b0, '0},
		'{ROW_WORD, OP_GET, 32'h0000_0008, 32'h0000_0000, 5'd0, 1'b0, '0},
		// equal counts, older stamp goes
		'{ROW_CAP,  OP_GET, 32'h0, 32'h0, 5'd3, 1'b0, '0},
		'{ROW_WORD, OP_PUT, 32'h0000_0009, 32'h0F0F_0F0F, 5'd0, 1'b0, '0},
		'{ROW_WORD, OP_GET, 32'h0000_0006, 32'h0000_0000, 5'd0, 1'b0, '0},
		'{ROW_WORD, OP_PUT, 32'h0000_000A, 32'hF0F0_F0F0, 5'd0, 1'b0, '0},
		'{ROW_WORD, OP_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, '0}
	};

	localparam logic [CAP_W-1:0] SEG_CAP [NSEG] = '{
		5'd16, 5'd4, 5'd1, 5'd0, 5'd31, 5'd8, 5'd2, 5'd16,
		5'd17, 5'd12, 5'd3, 5'd16, 5'd5, 5'd16, 5'd9
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_ready;
	logic             op;
	logic [KEY_W-1:0] key;
	logic [VAL_W-1:0] value;
	logic             out_valid;
	logic             out_ready;
	logic             hit;
	logic [VAL_W-1:0] read_value;
	logic             evicted;

	lfu_cache_lru_tiebreak dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.read_value (read_value),
		.evicted    (evicted)
	);

	// predictor state
	logic               store_valid [NSLOT];
	logic [KEY_W-1:0]   store_key   [NSLOT];
	logic [VAL_W-1:0]   store_val   [NSLOT];
	logic [CNT_W-1:0]   store_uses  [NSLOT];
	logic [STAMP_W-1:0] store_stamp [NSLOT];
	logic [STAMP_W-1:0] next_stamp;
	logic [CAP_W-1:0]   fill_count;
	logic [CAP_W-1:0]   cap_reg;

	lookup_res_t      lookups_due [$];
	logic [KEY_W-1:0] key_pool [POOL_N];

	int  errors;
	int  words_sent;
	int  results_seen;
	int  hits_seen;
	int  evictions_seen;
	int  cycles;
	int  send_idle_pct;
	int  recv_idle_pct;
	logic hold_req;

	function automatic lookup_res_t cache_apply(input logic o, input logic [KEY_W-1:0] k,
		input logic [VAL_W-1:0] v);
		int found;
		int free_slot;
		int victim;
		int slot;
		int lim;
		lookup_res_t r;
		found = -1;
		free_slot = -1;
		victim = -1;
		slot = -1;
		r = '0;
		lim = (cap_reg > NSLOT) ? NSLOT : int'(cap_reg);
		for (int i = 0; i < NSLOT; i++) begin
			if (store_valid[i]) begin
				if (found < 0 && store_key[i] == k)
					found = i;
				if (victim < 0)
					victim = i;
				else if (store_uses[i] < store_uses[victim] ||
					(store_uses[i] == store_uses[victim] &&
					store_stamp[i] < store_stamp[victim]))
					victim = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		r.hit = (found >= 0);
		if (o == OP_GET) begin
			if (found >= 0) begin
				r.rd = store_val[found];
				if (store_uses[found] != COUNT_MAX)
					store_uses[found]++;
				store_stamp[found] = next_stamp;
				next_stamp++;
			end
		end else if (lim != 0) begin
			if (found >= 0) begin
				store_val[found] = v;
				if (store_uses[found] != COUNT_MAX)
					store_uses[found]++;
				store_stamp[found] = next_stamp;
				next_stamp++;
			end else begin
				if (int'(fill_count) < lim && free_slot >= 0) begin
					slot = free_slot;
					fill_count++;
				end else if (victim >= 0) begin
					slot = victim;
					r.ev = 1'b1;
				end
				if (slot >= 0) begin
					store_valid[slot] = 1'b1;
					store_key[slot] = k;
					store_val[slot] = v;
					store_uses[slot] = COUNT_ONE;
					store_stamp[slot] = next_stamp;
					next_stamp++;
				end
			end
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("[%0t] mismatch on %s: got %h, want %h (result %0d)",
				$time, what, got, want, results_seen);
	endtask

	task automatic check_result();
		lookup_res_t want;
		if (lookups_due.size() == 0) begin
			report("unexpected word", 32'({hit, evicted}), 32'h0);
		end else begin
			want = lookups_due.pop_front();
			if (hit !== want.hit)
				report("hit", 32'(hit), 32'(want.hit));
			if (read_value !== want.rd)
				report("read_value", read_value, want.rd);
			if (evicted !== want.ev)
				report("evicted", 32'(evicted), 32'(want.ev));
		end
		results_seen++;
		if (hit === 1'b1)
			hits_seen++;
		if (evicted === 1'b1)
			evictions_seen++;
	endtask

	task automatic send_word(input logic o, input logic [KEY_W-1:0] k,
		input logic [VAL_W-1:0] v, input logic has_exp, input lookup_res_t exp);
		lookup_res_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		key <= k;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = cache_apply(o, k, v);
		lookups_due.push_back(has_exp ? exp : r);
		words_sent++;
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] c);
		in_valid <= 1'b0;
		@(posedge clk);
		while (lookups_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = c;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d words sent, %0d results", cycles,
			words_sent, results_seen);
		$display("== FAIL ==");
		$finish;
	end

	// receiver: random stalls, long hold on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				check_result();
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req <= 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		logic             o;
		logic [KEY_W-1:0] k;
		int               pool_hi;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		op = OP_GET;
		key = '0;
		value = '0;
		out_ready = 1'b0;
		hold_req = 1'b0;
		errors = 0;
		words_sent = 0;
		results_seen = 0;
		hits_seen = 0;
		evictions_seen = 0;
		cycles = 0;
		send_idle_pct = 35;
		recv_idle_pct = 76;
		for (int i = 0; i < NSLOT; i++) begin
			store_valid[i] = 1'b0;
			store_key[i] = '0;
			store_val[i] = '0;
			store_uses[i] = '0;
			store_stamp[i] = '0;
		end
		next_stamp = '0;
		fill_count = '0;
		cap_reg = CAPACITY_RST;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_N; i++)
			key_pool[i] = $urandom;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NROW; r++) begin
			if (DIRECTED_ROWS[r].kind == ROW_CAP)
				set_capacity(DIRECTED_ROWS[r].cap);
			else
				send_word(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].val,
					DIRECTED_ROWS[r].has_exp, DIRECTED_ROWS[r].exp);
		end

		for (int s = 0; s < NSEG; s++) begin
			set_capacity(SEG_CAP[s]);
			if (s == 5) begin
				send_idle_pct = 76;
				recv_idle_pct = 35;
			end else if (s == 10) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (s == 1 || s == 11)
				hold_req <= 1'b1;
			// keep the live key set a little larger than the store
			pool_hi = (SEG_CAP[s] + 5 > POOL_N - 1) ? POOL_N - 1 : SEG_CAP[s] + 5;
			for (int n = 0; n < SEG_WORDS; n++) begin
				o = ($urandom_range(99) < 55) ? OP_PUT : OP_GET;
				if ($urandom_range(99) < 12)
					k = $urandom;
				else
					k = key_pool[$urandom_range(pool_hi)];
				send_word(o, k, $urandom, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		while (lookups_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d words over %0d capacity settings (0, 1, 16 and 31 among them)",
			words_sent, NSEG + 4);
		$display("%0d results checked: %0d hits, %0d evictions, %0d mismatches",
			results_seen, hits_seen, evictions_seen, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_ram.sv
hw/rtl/lfu_cache_lru_tiebreak.sv
tb/lfu_cache_lru_tiebreak_tb.sv
